@@ hdl/spte_pkg.sv @@
// ----------------------------------------------------------------------------
// Signal phase time estimator package
// Shared widths, constants, stage structs, the status-code helper and the divide-by-ten helper.
// ----------------------------------------------------------------------------
package spte_pkg;

	localparam int PHASE_W  = 3;
	localparam int STATUS_W = 3;
	localparam int CTRL_W   = 16;
	localparam int TIME_W   = 32;
	localparam int CD_W     = 20;
	localparam int SECS_W   = 16;
	localparam int INTV_W   = 8;
	localparam int QUO_W    = 17;

	localparam int S_DATA_W = 56;
	localparam int M_DATA_W = 24;
	localparam int USER_W   = 3;

	// Status codes: green*1 + yellow*2 + red*3
	localparam logic [STATUS_W-1:0] ST_NONE   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_GREEN  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_YELLOW = 3'd2;
	localparam logic [STATUS_W-1:0] ST_RED    = 3'd3;

	localparam logic [CTRL_W-1:0] FAST_LIMIT_TENTHS   = 16'd30;
	localparam logic [CD_W-1:0]   NEAR_END_TENTHS     = 20'd30;
	localparam logic [INTV_W-1:0] READ_INTERVAL_RESET = 8'h01;
	localparam logic [SECS_W-1:0] SECS_MAX            = 16'hFFFF;

	// Elapsed tenths at or above this round to more than 65535 seconds
	localparam logic [TIME_W-1:0] SAT_DIFF_TENTHS = 32'd655355;

	// x/10 == (x * 0xCCCCD) >> 23, exact for any 20-bit x
	localparam logic [CD_W-1:0] RECIP10     = 20'hCCCCD;
	localparam int              RECIP_SHIFT = 23;

	// One reading held in the input stage
	typedef struct packed {
		logic [PHASE_W-1:0]  phase;
		logic [STATUS_W-1:0] status;
		logic [CTRL_W-1:0]   ctrl;
		logic [TIME_W-1:0]   now;
	} item_t;

	// Interval learning request, divided in stage two
	typedef struct packed {
		logic               we;
		logic [PHASE_W-1:0] phase;
		logic [1:0]         slot;
		logic               sat;
		logic [CD_W-1:0]    diff;
	} learn_req_t;

	// Write of a learned interval back into the phase state
	typedef struct packed {
		logic               we;
		logic [PHASE_W-1:0] phase;
		logic [1:0]         slot;
		logic [SECS_W-1:0]  secs;
	} learn_wr_t;

	// Stage two contents
	typedef struct packed {
		logic [PHASE_W-1:0]  phase;
		logic [STATUS_W-1:0] status;
		logic                in_range;
		logic                all_red;
		logic                ctrl_fast;
		logic [CD_W-1:0]     cd;
		logic [CTRL_W-1:0]   ctrl;
		learn_req_t          learn;
	} stage2_t;

	function automatic logic [STATUS_W-1:0] status_code(input logic g, input logic y,
		input logic r);
		return {2'b00, g} + {1'b0, y, 1'b0} + {1'b0, r, r};
	endfunction

	function automatic logic [QUO_W-1:0] div10(input logic [CD_W-1:0] x);
		logic [2*CD_W-1:0] prod;
		prod = {{CD_W{1'b0}}, x} * {{CD_W{1'b0}}, RECIP10};
		return prod[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
	endfunction

endpackage

@@ hdl/spte_update.sv @@
// ----------------------------------------------------------------------------
// Phase state update
// Per-phase state registers and the status-change / countdown logic applied
// to the word in the input stage.
// ----------------------------------------------------------------------------
module spte_update #(
	parameter int PHASE_COUNT = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [spte_pkg::INTV_W-1:0] read_interval,
	input  spte_pkg::item_t             item_s1,
	input  logic                        valid_s1,
	input  logic                        advance,
	input  spte_pkg::learn_wr_t         learn_wr,
	output logic                        hazard,
	output spte_pkg::stage2_t           stage_next
);
	import spte_pkg::*;

	localparam int IDX_W = (PHASE_COUNT > 1) ? $clog2(PHASE_COUNT) : 1;
	localparam int EXT_W = 5;

	logic [STATUS_W-1:0] last_status_q [PHASE_COUNT];
	logic [TIME_W-1:0]   change_time_q [PHASE_COUNT];
	logic                change_valid_q [PHASE_COUNT];
	logic [CTRL_W-1:0]   last_ctrl_q [PHASE_COUNT];
	logic [CD_W-1:0]     countdown_q [PHASE_COUNT];
	logic                all_red_q [PHASE_COUNT];
	logic [SECS_W-1:0]   interval_q [PHASE_COUNT][3];

	logic [EXT_W-1:0]    phase_ext, lw_ext;
	logic [IDX_W-1:0]    idx, lw_idx;
	logic                in_range;
	logic [STATUS_W-1:0] prev;
	logic                changed, reload, prev_known, new_known;
	logic [1:0]          slot_prev, slot_new;
	logic [SECS_W-1:0]   intv_new;
	logic [TIME_W-1:0]   diff;
	logic [CD_W-1:0]     cd_old, cd_dec, cd_reload, cd_next, intv_ext, ri_ext;
	logic                all_red_next;
	logic [CTRL_W-1:0]   last_ctrl;

	// Phase decode
	assign phase_ext = {2'b00, item_s1.phase};
	assign lw_ext    = {2'b00, learn_wr.phase};
	assign idx       = phase_ext[IDX_W-1:0];
	assign lw_idx    = lw_ext[IDX_W-1:0];
	assign in_range  = phase_ext < EXT_W'(PHASE_COUNT);

	// Status classification and interval slots
	always_comb begin
		prev       = last_status_q[idx];
		changed    = item_s1.status != prev;
		reload     = changed && (prev != ST_NONE);
		prev_known = prev inside {ST_GREEN, ST_YELLOW, ST_RED};
		new_known  = item_s1.status inside {ST_GREEN, ST_YELLOW, ST_RED};
		case (prev)
			ST_GREEN:  slot_prev = 2'd0;
			ST_YELLOW: slot_prev = 2'd1;
			ST_RED:    slot_prev = 2'd2;
			default:   slot_prev = 2'd0;
		endcase
		case (item_s1.status)
			ST_GREEN: begin
				slot_new = 2'd0;
				intv_new = interval_q[idx][0];
			end
			ST_YELLOW: begin
				slot_new = 2'd1;
				intv_new = interval_q[idx][1];
			end
			ST_RED: begin
				slot_new = 2'd2;
				intv_new = interval_q[idx][2];
			end
			default: begin
				slot_new = 2'd0;
				intv_new = '0;
			end
		endcase
	end

	// Countdown and all-red flag
	always_comb begin
		cd_old    = countdown_q[idx];
		last_ctrl = last_ctrl_q[idx];
		intv_ext  = {4'b0000, intv_new};
		ri_ext    = {12'b0, read_interval};
		cd_reload = new_known ? (intv_ext << 3) + (intv_ext << 1) : '0;
		cd_dec    = (cd_old > ri_ext) ? cd_old - ri_ext : '0;
		diff      = item_s1.now - change_time_q[idx];
		if (!changed) begin
			cd_next      = cd_dec;
			all_red_next = all_red_q[idx] && !(item_s1.ctrl > last_ctrl);
		end else if (reload) begin
			cd_next      = cd_reload;
			all_red_next = all_red_q[idx] || (prev == ST_YELLOW);
		end else begin
			cd_next      = cd_old;
			all_red_next = all_red_q[idx];
		end
	end

	// Reload would read the interval still being learned one stage ahead
	assign hazard = valid_s1 && in_range && reload && new_known && learn_wr.we &&
		(learn_wr.phase == item_s1.phase) && (learn_wr.slot == slot_new);

	// Stage two word
	always_comb begin
		stage_next.phase       = item_s1.phase;
		stage_next.status      = item_s1.status;
		stage_next.in_range    = in_range;
		stage_next.all_red     = all_red_next;
		stage_next.ctrl_fast   = (item_s1.ctrl <= FAST_LIMIT_TENTHS) &&
			(item_s1.ctrl != last_ctrl);
		stage_next.cd          = cd_next;
		stage_next.ctrl        = item_s1.ctrl;
		stage_next.learn.we    = in_range && reload && change_valid_q[idx] && prev_known;
		stage_next.learn.phase = item_s1.phase;
		stage_next.learn.slot  = slot_prev;
		stage_next.learn.sat   = diff >= SAT_DIFF_TENTHS;
		stage_next.learn.diff  = diff[CD_W-1:0];
	end

	// Per-phase state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PHASE_COUNT; p++) begin
				last_status_q[p]  <= ST_NONE;
				change_time_q[p]  <= '0;
				change_valid_q[p] <= 1'b0;
				last_ctrl_q[p]    <= '0;
				countdown_q[p]    <= '0;
				all_red_q[p]      <= 1'b0;
				for (int k = 0; k < 3; k++)
					interval_q[p][k] <= '0;
			end
		end else begin
			if (advance && in_range) begin
				if (changed)
					last_status_q[idx] <= item_s1.status;
				if (reload) begin
					change_time_q[idx]  <= item_s1.now;
					change_valid_q[idx] <= 1'b1;
				end
				countdown_q[idx] <= cd_next;
				all_red_q[idx]   <= all_red_next;
				last_ctrl_q[idx] <= item_s1.ctrl;
			end
			for (int p = 0; p < PHASE_COUNT; p++) begin
				for (int k = 0; k < 3; k++) begin
					if (learn_wr.we && (lw_idx == IDX_W'(p)) && (learn_wr.slot == 2'(k)))
						interval_q[p][k] <= learn_wr.secs;
				end
			end
		end
	end

endmodule

@@ hdl/spte_finish.sv @@
// ----------------------------------------------------------------------------
// Divide and answer stage
// Rounds the learned interval to seconds, picks the answer, divides it by ten
// and holds the result word for the output side.
// ----------------------------------------------------------------------------
module spte_finish (
	input  logic                          clk,
	input  logic                          arst_n,
	input  spte_pkg::stage2_t             stage_next,
	input  logic                          load,
	output logic                          ready,
	output spte_pkg::learn_wr_t           learn_wr,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [spte_pkg::M_DATA_W-1:0] m_tdata,   // [2:0] out_status, [18:3] time_left_seconds
	output logic [spte_pkg::USER_W-1:0]   m_tuser    // [2:0] out_phase
);
	import spte_pkg::*;

	stage2_t             stage_s2;
	logic                valid_s2;
	logic                adv_s2;
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [SECS_W-1:0]   out_time_q;
	logic [PHASE_W-1:0]  out_phase_q;

	logic [QUO_W-1:0]    lq;
	logic [CD_W-1:0]     lq10, lrem;
	logic [SECS_W-1:0]   secs;
	logic                use_ctrl;
	logic [CD_W-1:0]     div_in;
	logic [QUO_W-1:0]    quo;
	logic [SECS_W-1:0]   answer;

	assign adv_s2 = !out_valid_q || m_tready;
	assign ready  = !valid_s2 || adv_s2;

	// Learned interval: round half up, saturate
	always_comb begin
		lq   = div10(stage_s2.learn.diff);
		lq10 = CD_W'({lq, 3'b000}) + CD_W'({lq, 1'b0});
		lrem = stage_s2.learn.diff - lq10;
		if (stage_s2.learn.sat)
			secs = SECS_MAX;
		else
			secs = lq[SECS_W-1:0] + SECS_W'(lrem >= CD_W'(5));
	end

	// Write stays up while the word sits here; repeats are harmless
	always_comb begin
		learn_wr.we    = valid_s2 && stage_s2.learn.we;
		learn_wr.phase = stage_s2.learn.phase;
		learn_wr.slot  = stage_s2.learn.slot;
		learn_wr.secs  = secs;
	end

	// Answer select and divide
	always_comb begin
		use_ctrl = !stage_s2.all_red && (stage_s2.ctrl_fast ||
			((stage_s2.cd < NEAR_END_TENTHS) && (stage_s2.cd < CD_W'(stage_s2.ctrl))));
		div_in   = use_ctrl ? CD_W'({1'b0, stage_s2.ctrl} + 17'd9) : stage_s2.cd;
		quo      = div10(div_in);
		if (!stage_s2.in_range)
			answer = '0;
		else if (quo > QUO_W'(SECS_MAX))
			answer = SECS_MAX;
		else
			answer = quo[SECS_W-1:0];
	end

	// Stage two register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load)
			stage_s2 <= stage_next;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s2) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s2) begin
			out_status_q <= stage_s2.status;
			out_time_q   <= answer;
			out_phase_q  <= stage_s2.phase;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b00000, out_time_q, out_status_q};
	assign m_tuser  = out_phase_q;

endmodule

@@ hdl/signal_phase_time_estimator.sv @@
// ----------------------------------------------------------------------------
// Signal phase time estimator
// Tracks each signal phase's status and learned interval lengths and gives an
// estimate of the whole seconds left until the phase changes.
// ----------------------------------------------------------------------------
// Takes one reading per clock, unless a hazard or a stalled output holds the
// input stage, and returns one result word per reading: the input register
// feeds the per-phase state update, the stage-two register feeds the divide and
// answer select, and the output register holds the word. A reading that
// switches a phase back to the status whose interval the reading just ahead
// of it (same phase) is still learning waits in the input register while that
// word sits in stage two, since the reload needs that freshly rounded value.
// Per-phase state sits in flip-flops and is cleared by reset at once. The user
// must write the read interval register, through the cfg port, which is always
// ready, only while the block is idle; the block itself does not enforce this.
module signal_phase_time_estimator #(
	parameter int PHASE_COUNT = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [spte_pkg::INTV_W-1:0]   cfg_data,  // [7:0] read_interval_tenths
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [0] green_on, [1] yellow_on, [2] red_on, [18:3] controller_tenths,
	// [50:19] now_tenths
	input  logic [spte_pkg::S_DATA_W-1:0] s_tdata,
	input  logic [spte_pkg::USER_W-1:0]   s_tuser,   // [2:0] phase_index
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [spte_pkg::M_DATA_W-1:0] m_tdata,   // [2:0] out_status, [18:3] time_left_seconds
	output logic [spte_pkg::USER_W-1:0]   m_tuser    // [2:0] out_phase
);
	import spte_pkg::*;

	logic [INTV_W-1:0] read_interval_q;
	item_t             item_s1;
	logic              valid_s1;
	logic              adv_s1;
	logic              hazard;
	logic              s2_ready;
	stage2_t           stage_next;
	learn_wr_t         learn_wr;

	// Config register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_interval_q <= READ_INTERVAL_RESET;
		end else if (cfg_valid) begin
			read_interval_q <= cfg_data;
		end
	end

	// Input stage handshake
	assign adv_s1   = valid_s1 && !hazard && s2_ready;
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.phase  <= s_tuser;
			item_s1.status <= status_code(s_tdata[0], s_tdata[1], s_tdata[2]);
			item_s1.ctrl   <= s_tdata[18:3];
			item_s1.now    <= s_tdata[50:19];
		end
	end

	spte_update #(
		.PHASE_COUNT(PHASE_COUNT)
	) u_update (
		.clk           (clk),
		.arst_n        (arst_n),
		.read_interval (read_interval_q),
		.item_s1       (item_s1),
		.valid_s1      (valid_s1),
		.advance       (adv_s1),
		.learn_wr      (learn_wr),
		.hazard        (hazard),
		.stage_next    (stage_next)
	);

	spte_finish u_finish (
		.clk        (clk),
		.arst_n     (arst_n),
		.stage_next (stage_next),
		.load       (adv_s1),
		.ready      (s2_ready),
		.learn_wr   (learn_wr),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

@@ hdl/spte_checker.sv @@
// ----------------------------------------------------------------------------
// Signal phase time estimator port checker
// Watches the top-level result port for output stability and legal words.
// ----------------------------------------------------------------------------
module spte_port_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [spte_pkg::M_DATA_W-1:0] m_tdata,
	input logic [spte_pkg::USER_W-1:0]   m_tuser
);
	import spte_pkg::*;

	// A held result word stays valid
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	// A held result word keeps its contents
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// No result word while reset is held
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result word shown during reset");

	// Status code is a sum of lamp weights, never seven; padding bits stay zero
	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] != 3'd7) && (m_tdata[23:19] == 5'd0))
		else $error("illegal status code or padding in result word");

endmodule

bind signal_phase_time_estimator spte_port_checker u_spte_port_checker (.*);

@@ verif/spte_checker.sv @@
// ----------------------------------------------------------------------------
// Signal phase time estimator checker
// Watches the cfg, reading and result channels of the estimator, keeps its own
// per-phase copy of the learned intervals and countdowns, predicts the result
// word of every accepted reading and compares it field by field.
// ----------------------------------------------------------------------------
module spte_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [spte_pkg::INTV_W-1:0]   cfg_data,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [spte_pkg::S_DATA_W-1:0] s_tdata,
	input  logic [spte_pkg::USER_W-1:0]   s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [spte_pkg::M_DATA_W-1:0] m_tdata,
	input  logic [spte_pkg::USER_W-1:0]   m_tuser,
	output int                            pending,
	output int                            errors,
	output int                            readings_seen,
	output int                            words_checked,
	output int                            settings_seen
);
	import spte_pkg::*;

	localparam int NUM_PHASES = 8;

	typedef struct {
		logic [PHASE_W-1:0]  phase;
		logic [STATUS_W-1:0] status;
		logic [SECS_W-1:0]   secs;
	} estimate_t;

	estimate_t estimate_q[$];
	estimate_t head;

	// Shadow of the per-phase tracking state
	logic [STATUS_W-1:0] seen_status  [NUM_PHASES];
	logic [TIME_W-1:0]   change_stamp [NUM_PHASES];
	logic                stamp_valid  [NUM_PHASES];
	logic [CTRL_W-1:0]   prev_ctrl    [NUM_PHASES];
	logic [CD_W-1:0]     countdown    [NUM_PHASES];
	logic                red_hold     [NUM_PHASES];
	logic [SECS_W-1:0]   learned_secs [NUM_PHASES][3];
	logic [INTV_W-1:0]   decrement;

	// Update the shadow state for one reading and queue its expected word.
	// Every 3-bit index names an existing phase, so all readings update state.
	task automatic estimate_reading(input logic [PHASE_W-1:0] ph, input logic g,
		input logic y, input logic r, input logic [CTRL_W-1:0] ctrl,
		input logic [TIME_W-1:0] now);
		logic [STATUS_W-1:0] code;
		logic [STATUS_W-1:0] prior;
		logic [CD_W-1:0]     cd;
		logic [TIME_W-1:0]   elapsed;
		logic [TIME_W-1:0]   secs;
		logic [TIME_W-1:0]   answer;
		logic [TIME_W-1:0]   ctrl_ceil;
		estimate_t           est;
		code = 3'(g) + (y ? 3'd2 : 3'd0) + (r ? 3'd3 : 3'd0);
		prior = seen_status[ph];
		cd = countdown[ph];
		ctrl_ceil = (32'(ctrl) + 32'd9) / 32'd10;
		if (code != prior) begin
			if (prior == ST_NONE) begin
				// first status seen: record only
				seen_status[ph] = code;
			end else begin
				// learn the interval that just ended, rounded half up
				if (stamp_valid[ph] && prior >= ST_GREEN && prior <= ST_RED) begin
					elapsed = now - change_stamp[ph];
					secs = elapsed / 32'd10 + ((elapsed % 32'd10) >= 32'd5 ? 32'd1 : 32'd0);
					if (secs > 32'(SECS_MAX))
						secs = 32'(SECS_MAX);
					learned_secs[ph][prior - 3'd1] = secs[SECS_W-1:0];
				end
				if (prior == ST_YELLOW)
					red_hold[ph] = 1'b1;
				seen_status[ph] = code;
				change_stamp[ph] = now;
				stamp_valid[ph] = 1'b1;
				// reload from the learned length of the new status
				if (code >= ST_GREEN && code <= ST_RED)
					cd = CD_W'(32'(learned_secs[ph][code - 3'd1]) * 32'd10);
				else
					cd = '0;
			end
		end else begin
			cd = (cd > CD_W'(decrement)) ? cd - CD_W'(decrement) : '0;
			if (red_hold[ph] && ctrl > prev_ctrl[ph])
				red_hold[ph] = 1'b0;
		end
		countdown[ph] = cd;

		// pick countdown or controller time
		if (red_hold[ph])
			answer = 32'(cd) / 32'd10;
		else if (ctrl <= FAST_LIMIT_TENTHS && ctrl != prev_ctrl[ph])
			answer = ctrl_ceil;
		else if (cd < NEAR_END_TENTHS && 32'(cd) < 32'(ctrl))
			answer = ctrl_ceil;
		else
			answer = 32'(cd) / 32'd10;
		if (answer > 32'(SECS_MAX))
			answer = 32'(SECS_MAX);
		prev_ctrl[ph] = ctrl;

		est.phase = ph;
		est.status = code;
		est.secs = answer[SECS_W-1:0];
		estimate_q.push_back(est);
	endtask

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PHASES; p++) begin
				seen_status[p] = ST_NONE;
				change_stamp[p] = '0;
				stamp_valid[p] = 1'b0;
				prev_ctrl[p] = '0;
				countdown[p] = '0;
				red_hold[p] = 1'b0;
				for (int k = 0; k < 3; k++)
					learned_secs[p][k] = '0;
			end
			decrement = READ_INTERVAL_RESET;
			estimate_q.delete();
			pending = 0;
			errors = 0;
			readings_seen = 0;
			words_checked = 0;
			settings_seen = 0;
		end else begin
			// register write
			if (cfg_valid && cfg_ready) begin
				decrement = cfg_data;
				settings_seen++;
			end
			// accepted reading
			if (s_tvalid && s_tready) begin
				estimate_reading(s_tuser, s_tdata[0], s_tdata[1], s_tdata[2],
					s_tdata[18:3], s_tdata[50:19]);
				readings_seen++;
			end
			// accepted result word
			if (m_tvalid && m_tready) begin
				if (estimate_q.size() == 0) begin
					$error("result word with no reading outstanding: phase %0d", m_tuser);
					errors++;
				end else begin
					head = estimate_q.pop_front();
					check_field("out_phase", head.phase, m_tuser);
					check_field("out_status", head.status, m_tdata[2:0]);
					check_field("time_left_seconds", head.secs, m_tdata[18:3]);
					words_checked++;
				end
			end
			pending = estimate_q.size();
		end
	end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// Signal phase time estimator testbench
// Drives directed lamp sequences, then traffic-like green/yellow/red cycles
// mixed with random readings under several read intervals and handshake
// idling mixes; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb;
	import spte_pkg::*;

	localparam int ITEMS_PER_SETTING = 200;
	localparam int NUM_SETTINGS      = 8;
	localparam int HOLD_CYCLES       = 120;
	localparam int QUIET_LIMIT       = 4000;
	localparam int TAIL_CYCLES       = 12;

	// Lamp bits as packed in the low bits of s_tdata
	localparam logic [2:0] LAMPS_OFF    = 3'b000;
	localparam logic [2:0] LAMPS_GREEN  = 3'b001;
	localparam logic [2:0] LAMPS_YELLOW = 3'b010;
	localparam logic [2:0] LAMPS_RED    = 3'b100;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [INTV_W-1:0]   cfg_data;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;   // [0] green, [1] yellow, [2] red, [18:3] ctrl, [50:19] now
	logic [USER_W-1:0]   s_tuser;   // [2:0] phase_index
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;   // [2:0] out_status, [18:3] time_left_seconds
	logic [USER_W-1:0]   m_tuser;   // [2:0] out_phase

	int pending;
	int errors;
	int readings_seen;
	int words_checked;
	int settings_seen;

	int unsigned gap_pct;
	int unsigned stall_pct;
	logic        long_hold;
	int          quiet;

	// Traffic model per phase
	logic [2:0]        cycle_lamps [8];
	logic [CTRL_W-1:0] ctrl_left   [8];
	logic [TIME_W-1:0] last_wall   [8];
	logic [TIME_W-1:0] wall;
	logic [INTV_W-1:0] interval_plan [NUM_SETTINGS];
	logic [PHASE_W-1:0] cur_ph;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	signal_phase_time_estimator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	spte_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.pending       (pending),
		.errors        (errors),
		.readings_seen (readings_seen),
		.words_checked (words_checked),
		.settings_seen (settings_seen)
	);

	// Offer one reading word, with random idle cycles ahead of it
	task automatic send_reading(input logic [PHASE_W-1:0] ph, input logic [2:0] lamps,
		input logic [CTRL_W-1:0] ctrl, input logic [TIME_W-1:0] now);
		while ($urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= ph;
		s_tdata <= {5'd0, now, ctrl, lamps};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic write_interval(input logic [INTV_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stop offering and wait until every reading has its result word back
	task automatic drain;
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	// Well-formed green -> yellow -> red cycle with a falling controller time
	task automatic send_traffic(input logic [PHASE_W-1:0] ph);
		logic [TIME_W-1:0] span;
		span = wall - last_wall[ph];
		last_wall[ph] = wall;
		if (32'(ctrl_left[ph]) <= span || $urandom_range(0, 9) == 0) begin
			case (cycle_lamps[ph])
				LAMPS_GREEN:  cycle_lamps[ph] = LAMPS_YELLOW;
				LAMPS_YELLOW: cycle_lamps[ph] = LAMPS_RED;
				default:      cycle_lamps[ph] = LAMPS_GREEN;
			endcase
			ctrl_left[ph] = CTRL_W'($urandom_range(0, 600));
		end else begin
			ctrl_left[ph] = ctrl_left[ph] - span[CTRL_W-1:0];
			// controller extends the phase now and then
			if ($urandom_range(0, 15) == 0)
				ctrl_left[ph] = ctrl_left[ph] + CTRL_W'($urandom_range(1, 60));
		end
		send_reading(ph, cycle_lamps[ph], ctrl_left[ph], wall);
		wall = wall + $urandom_range(1, 25);
		if ($urandom_range(0, 199) == 0)
			wall = wall + $urandom();
	endtask

	// Arbitrary lamps, controller time and timestamp
	task automatic send_noise(input logic [PHASE_W-1:0] ph);
		logic [CTRL_W-1:0] ctrl;
		logic [TIME_W-1:0] now;
		ctrl = $urandom_range(0, 1) ? CTRL_W'($urandom_range(0, 65535))
			: CTRL_W'($urandom_range(0, 40));
		now = $urandom_range(0, 1) ? TIME_W'($urandom()) : wall;
		send_reading(ph, 3'($urandom_range(0, 7)), ctrl, now);
	endtask

	// Result side: random stalls, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				long_hold = 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// Watchdog on cycles with no word moving on any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("signal_phase_time_estimator test failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		gap_pct = 0;
		stall_pct = 0;
		long_hold = 1'b0;
		quiet = 0;
		wall = $urandom();
		cur_ph = '0;
		for (int p = 0; p < 8; p++) begin
			cycle_lamps[p] = LAMPS_RED;
			ctrl_left[p] = '0;
			last_wall[p] = wall;
		end
		interval_plan[0] = 8'd255;
		interval_plan[1] = 8'd0;
		interval_plan[2] = INTV_W'($urandom_range(2, 254));
		interval_plan[3] = 8'd1;
		interval_plan[4] = INTV_W'($urandom_range(2, 30));
		interval_plan[5] = 8'd10;
		interval_plan[6] = INTV_W'($urandom_range(2, 254));
		interval_plan[7] = 8'd255;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: rounding, hold after yellow, clearing on a rising
		// controller time, fast controller path
		send_reading(3'd0, LAMPS_GREEN, 16'd0, 32'd0);
		send_reading(3'd0, LAMPS_GREEN, 16'd30, 32'd5);
		send_reading(3'd0, LAMPS_YELLOW, 16'hFFFF, 32'd15);
		send_reading(3'd0, LAMPS_RED, 16'd31, 32'd29);
		send_reading(3'd0, LAMPS_RED, 16'd40, 32'd40);
		send_reading(3'd0, LAMPS_GREEN, 16'd0, 32'd100);
		send_reading(3'd0, LAMPS_GREEN, 16'd0, 32'd101);
		// saturated learned interval across a timestamp wrap
		send_reading(3'd1, LAMPS_GREEN, 16'd100, 32'd0);
		send_reading(3'd1, LAMPS_YELLOW, 16'd100, 32'hFFFF_FFFF);
		send_reading(3'd1, LAMPS_GREEN, 16'd90, 32'h000A_0000);
		send_reading(3'd1, LAMPS_YELLOW, 16'hFFFF, 32'h000A_0010);
		send_reading(3'd1, LAMPS_YELLOW, 16'hFFFF, 32'h000A_0011);
		// lamp combinations outside green, yellow, red
		send_reading(3'd2, LAMPS_GREEN | LAMPS_RED, 16'd50, 32'd1000);
		send_reading(3'd2, LAMPS_YELLOW | LAMPS_RED, 16'd50, 32'd1010);
		send_reading(3'd2, LAMPS_GREEN | LAMPS_YELLOW | LAMPS_RED, 16'd50, 32'd1020);
		send_reading(3'd2, LAMPS_OFF, 16'd50, 32'd1030);
		send_reading(3'd2, LAMPS_GREEN, 16'd5, 32'd1050);
		send_reading(3'd2, LAMPS_GREEN | LAMPS_YELLOW, 16'd5, 32'd1060);
		// no lamps on a fresh phase
		send_reading(3'd3, LAMPS_OFF, 16'd25, 32'd7);
		// switch back to the status whose interval is being learned
		send_reading(3'd4, LAMPS_RED, 16'd300, 32'd190);
		send_reading(3'd4, LAMPS_GREEN, 16'd300, 32'd200);
		send_reading(3'd4, LAMPS_YELLOW, 16'd20, 32'd237);
		send_reading(3'd4, LAMPS_GREEN, 16'd20, 32'd240);
		send_reading(3'd4, LAMPS_GREEN, 16'hFFFF, 32'd241);
		send_reading(3'd7, LAMPS_YELLOW, 16'd31, 32'hFFFF_FFFF);
		drain();

		// Random traffic under each read interval and idling mix
		for (int s = 0; s < NUM_SETTINGS; s++) begin
			write_interval(interval_plan[s]);
			case (s % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 49; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 49; end
				default: begin gap_pct = 27; stall_pct = 27; end
			endcase
			if ($urandom_range(0, 3) == 0)
				wall = 32'hFFFF_FC00;
			for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
				if (s == 2 && i == 20)
					long_hold = 1'b1;
				if (s == 5 && i == 100)
					drain();
				if ($urandom_range(0, 3) != 0)
					cur_ph = PHASE_W'($urandom_range(0, 7));
				if ($urandom_range(0, 99) < 75)
					send_traffic(cur_ph);
				else
					send_noise(cur_ph);
			end
			drain();
		end

		gap_pct = 0;
		stall_pct = 0;
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Checked %0d result words for %0d readings over %0d read-interval writes,",
			words_checked, readings_seen, settings_seen);
		$display("with traffic cycles, odd lamp mixes, timestamp wraps and handshake stalls.");
		if (errors == 0 && pending == 0)
			$display("signal_phase_time_estimator test passed");
		else
			$display("signal_phase_time_estimator test failed");
		$finish;
	end

endmodule
